// ----- rtl/per_user_token_bucket_limiter_unit_assert.svh -----
// Assertion macros shared by the limiter checkers.
// Depends on clk and rst_n being visible at the point of use.
`ifndef PER_USER_TOKEN_BUCKET_LIMITER_UNIT_ASSERT_SVH
`define PER_USER_TOKEN_BUCKET_LIMITER_UNIT_ASSERT_SVH
// Same-cycle implication, gated by reset.
`define PTBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked during reset too.
`define PTBL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/ptbl_pkg.sv -----
// Shared constants and types of the token bucket limiter.
// No dependencies.
package ptbl_pkg;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int USER_W = 32;
  localparam int TOK_W = 16;
  localparam int TIME_W = 64;
  localparam int NOW_W = 63;
  localparam int INT_W = 32;
  localparam int RAM_W = USER_W + TOK_W + TIME_W;
  localparam int DIV_STEPS = TIME_W;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);
  localparam logic [TOK_W-1:0] CAP_RESET = 16'd64;
  localparam logic [INT_W-1:0] INT_RESET = 32'd1000000;
  localparam logic REG_CAP = 1'b0;
  localparam logic REG_INT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_CHK, ST_DIV, ST_UPD, ST_DONE
  } ptbl_state_t;
endpackage

// ----- rtl/ptbl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptbl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/ptbl_div.sv -----
// Restoring divider, one quotient bit per cycle: 64-bit by 32-bit.
// Depends on ptbl_pkg.
module ptbl_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [ptbl_pkg::TIME_W-1:0]            dividend,
  input  logic [ptbl_pkg::INT_W-1:0]             divisor,
  output logic                                   done,
  output logic [ptbl_pkg::TIME_W-1:0]            quo,
  output logic [ptbl_pkg::INT_W-1:0]             rem
);
  import ptbl_pkg::*;

  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [INT_W-1:0]  rem_r, rem_nxt, dvs_r;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [INT_W:0]    trial;
  logic [INT_W:0]    diff;

  always_comb begin
    trial    = {rem_r, quo_r[TIME_W-1]};
    diff     = trial - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[INT_W]) begin
        rem_nxt = diff[INT_W-1:0];
        quo_nxt = {quo_r[TIME_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[INT_W-1:0];
        quo_nxt = {quo_r[TIME_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = !busy_r && (cnt_r == STEP_W'(DIV_STEPS));
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

// ----- rtl/per_user_token_bucket_limiter_unit.sv -----
// Per-user token bucket limiter: bucket table in one RAM, filled in order.
// Steps: a bypassed word (limiter off or probe marked) goes straight to the
// result; else the table is scanned entry by entry, a found user is refilled
// by the 64-step divider and a new user is appended. One request at a time.
// Reset (synchronous, rst_n low): table empty (fill count zero), registers at
// capacity 64 and interval 1000000 ns; no clearing pass needed.
module per_user_token_bucket_limiter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptbl_pkg::USER_W-1:0]   in_user_id,
  input  logic [ptbl_pkg::NOW_W-1:0]    in_now_ns,
  input  logic                          in_probe_marked,
  input  logic                          in_limiter_enabled,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_drop_send,
  output logic                          out_table_full,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ptbl_pkg::*;

  ptbl_state_t st_r, st_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt, fill_r, fill_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [USER_W-1:0] user_r;
  logic [NOW_W-1:0]  now_r;
  logic [TOK_W-1:0]  tok_r, tok_nxt, cap_r;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [INT_W-1:0]  int_r;
  logic              refill_r, refill_nxt;
  logic              drop_r, drop_nxt, full_r, full_nxt;
  logic              out_valid_r, out_drop_r, out_full_r;
  logic              load_out;

  // table RAM: {user, tokens, last refill time}
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  logic [USER_W-1:0] rd_user;
  logic [TOK_W-1:0]  rd_tok;
  logic [TIME_W-1:0] rd_last;
  logic [TIME_W-1:0] now_ext, elapsed;

  // divider link
  logic              div_start;
  logic              div_done;
  logic [TIME_W-1:0] div_quo;
  logic [INT_W-1:0]  div_rem;
  logic [INT_W-1:0]  div_dvs;

  // refill arithmetic
  logic [TOK_W:0]    tok_sum;
  logic [TOK_W-1:0]  tok_ref;
  logic [TIME_W-1:0] last_ref;
  logic              cfg_wr;

  assign {rd_user, rd_tok, rd_last} = ram_rdata;
  assign now_ext = {1'b0, now_r};
  assign elapsed = (now_ext > rd_last) ? (now_ext - rd_last) : '0;
  assign div_dvs = (int_r == '0) ? INT_W'(1) : int_r;

  ptbl_ram #(.W(RAM_W), .D(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptbl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // refill: saturate at capacity; last time advances by whole intervals,
  // which is now minus the remainder
  always_comb begin
    tok_sum  = {1'b0, tok_r} + {1'b0, div_quo[TOK_W-1:0]};
    tok_ref  = tok_r;
    last_ref = last_r;
    if (refill_r && (div_quo != '0)) begin
      if (div_quo >= TIME_W'(cap_r)) begin
        tok_ref = cap_r;
      end else if (tok_sum > {1'b0, cap_r}) begin
        tok_ref = cap_r;
      end else begin
        tok_ref = tok_sum[TOK_W-1:0];
      end
      last_ref = now_ext - TIME_W'(div_rem);
    end
  end

  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    fill_nxt   = fill_r;
    slot_nxt   = slot_r;
    tok_nxt    = tok_r;
    last_nxt   = last_r;
    refill_nxt = refill_r;
    drop_nxt   = drop_r;
    full_nxt   = full_r;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = idx_r[IDX_W-1:0];
    ram_wdata  = {user_r, tok_r, last_r};
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          drop_nxt = 1'b0;
          full_nxt = 1'b0;
          idx_nxt  = '0;
          st_nxt   = (!in_limiter_enabled || in_probe_marked) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == fill_r) begin
          if (fill_r == CNT_W'(TABLE_ENTRIES)) begin
            // fail open: no room for a new user
            full_nxt = 1'b1;
            st_nxt   = ST_DONE;
          end else begin
            slot_nxt   = fill_r[IDX_W-1:0];
            tok_nxt    = cap_r;
            last_nxt   = now_ext;
            refill_nxt = 1'b0;
            fill_nxt   = fill_r + 1'b1;
            st_nxt     = ST_UPD;
          end
        end else begin
          st_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (rd_user == user_r) begin
          slot_nxt   = idx_r[IDX_W-1:0];
          tok_nxt    = rd_tok;
          last_nxt   = rd_last;
          refill_nxt = 1'b1;
          div_start  = 1'b1;
          st_nxt     = ST_DIV;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt  = ST_SCAN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          st_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // take one token or drop
        ram_we = 1'b1;
        if (tok_ref != '0) begin
          ram_wdata = {user_r, tok_ref - 1'b1, last_ref};
        end else begin
          ram_wdata = {user_r, tok_ref, last_ref};
          drop_nxt  = 1'b1;
        end
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
      int_r       <= INT_RESET;
    end else begin
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_CAP: cap_r <= pwdata[TOK_W-1:0];
          REG_INT: int_r <= pwdata;
          default: ;
        endcase
      end
    end
    slot_r   <= slot_nxt;
    tok_r    <= tok_nxt;
    last_r   <= last_nxt;
    refill_r <= refill_nxt;
    drop_r   <= drop_nxt;
    full_r   <= full_nxt;
    if (st_r == ST_IDLE && in_valid) begin
      user_r <= in_user_id;
      now_r  <= in_now_ns;
    end
    if (load_out) begin
      out_drop_r <= drop_r;
      out_full_r <= full_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drop_send  = out_drop_r;
  assign out_table_full = out_full_r;
  assign pready         = 1'b1;
  assign prdata         = (paddr[2] == REG_CAP) ? {16'd0, cap_r} : int_r;
endmodule

// ----- rtl/ptbl_checker.sv -----
// Port-level checker for the limiter, bound to the top level.
// Depends on per_user_token_bucket_limiter_unit_assert.svh.
`include "per_user_token_bucket_limiter_unit_assert.svh"
module ptbl_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_drop_send,
  input logic out_table_full,
  input logic pready
);
  `PTBL_ASSERT_IMP(a_hold_out, out_valid && !out_ready, ##1 out_valid, "result word lost")
  `PTBL_ASSERT_IMP(a_excl, out_valid, !(out_drop_send && out_table_full), "drop and full")
  `PTBL_ASSERT_IMP(a_pready, 1'b1, pready, "pready low")
  `PTBL_ASSERT_NXT(a_rst, !rst_n, !out_valid, "valid after reset")
endmodule

bind per_user_token_bucket_limiter_unit ptbl_checker u_ptbl_checker (.*);
